@@ src/command_ack_done_retry_engine_macros.svh @@
// Assertion helpers shared by the engine's modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef COMMAND_ACK_DONE_RETRY_ENGINE_MACROS_SVH
`define COMMAND_ACK_DONE_RETRY_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define CADRE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define CADRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CADRE_ASSERT_IMPL(label, ante, cons)
`define CADRE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/cadre_pkg.sv @@
package cadre_pkg;

  // Input item codes.
  typedef enum logic [2:0] {
    MODE_SPEAR_SEND = 3'd0,
    MODE_SPEAR_ACK  = 3'd1,
    MODE_SPEAR_DONE = 3'd2,
    MODE_TICK       = 3'd3,
    MODE_ARM_SEND   = 3'd4,
    MODE_ARM_ACK    = 3'd5,
    MODE_ARM_DONE   = 3'd6
  } mode_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RESEND_PERIOD = 2'd0;
  localparam logic [1:0] CFG_DONE_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_MAX_RETRY     = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] RESEND_PERIOD_RST = 16'd5;
  localparam logic [15:0] DONE_TIMEOUT_RST  = 16'd100;
  localparam logic [3:0]  MAX_RETRY_RST     = 4'd3;

  // Result kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] cmd_code;
    logic       done_ok;
    logic [7:0] area_code;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] status_code;
    logic [7:0] spear_code;
    logic [7:0] area_out;
    logic       event_ok;
    logic       last;
  } res_t;

  // Tick counter increment that sticks at all ones.
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Builds a result marked as the final one of its item.
  function automatic res_t mk_res(input logic kind, input logic [7:0] st,
                                  input logic [7:0] sp, input logic [7:0] area,
                                  input logic ok);
    res_t r;
    r.kind        = kind;
    r.status_code = st;
    r.spear_code  = sp;
    r.area_out    = area;
    r.event_ok    = ok;
    r.last        = 1'b1;
    return r;
  endfunction

endpackage

@@ src/command_ack_done_retry_engine.sv @@
// Command sender with ACK, DONE and a retry budget for spearhead commands. Each input beat
// is an event (spearhead send/ack/done, tick, arm send/ack/done); it yields zero, one or
// two result beats, the final one marked by last. An item waits in the input register
// while the decision logic works on it; when it is taken, its results are loaded into the
// result register, and they leave it one beat per cycle while out_ready is high. Items
// that give at most one result go through at one per cycle when the output does not
// stall; an arm send of a nonzero command gives an idle frame plus the command frame, and
// no new item is taken while both wait at the result register's single output port.
// Configuration writes take effect at once and belong in idle periods.
module command_ack_done_retry_engine
  import cadre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic       in_valid_r;
  in_t        in_data_r;
  logic       take;
  logic       fire;
  logic [1:0] res_cnt;
  res_t       res0, res1;

  // Input register: refills when empty or when its beat moves into the decision stage.
  assign fire     = in_valid_r && take;
  assign in_ready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  cadre_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (in_data_r),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  cadre_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ src/cadre_core.sv @@
`include "command_ack_done_retry_engine_macros.svh"

// Channel state, configuration registers and the per-item decision logic.
module cadre_core
  import cadre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  logic        fire,
  input  in_t         item,
  output logic [1:0]  res_cnt,
  output res_t        res0,
  output res_t        res1
);

  logic [15:0] period_r, timeout_r;
  logic [3:0]  max_retry_r;

  logic        active_r, active_nxt;
  logic        wait_r, wait_nxt;
  logic        acked_r, acked_nxt;
  logic [7:0]  pending_r, pending_nxt;
  logic [3:0]  tries_r, tries_nxt;
  logic [15:0] since_send_r, since_send_nxt;
  logic [15:0] since_start_r, since_start_nxt;
  logic        arm_wait_r, arm_wait_nxt;
  logic [7:0]  arm_pending_r, arm_pending_nxt;
  logic [15:0] arm_since_r, arm_since_nxt;
  logic [7:0]  area_r, area_nxt;

  logic [15:0] ss_inc, st_inc, as_inc;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= RESEND_PERIOD_RST;
      timeout_r   <= DONE_TIMEOUT_RST;
      max_retry_r <= MAX_RETRY_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_RESEND_PERIOD) period_r <= cfg_wdata;
      if (cfg_idx == CFG_DONE_TIMEOUT) timeout_r <= cfg_wdata;
      if (cfg_idx == CFG_MAX_RETRY) max_retry_r <= cfg_wdata[3:0];
    end
  end

  assign ss_inc = sat_inc16(since_send_r);
  assign st_inc = sat_inc16(since_start_r);
  assign as_inc = sat_inc16(arm_since_r);

  // Next state and the results that the current item causes.
  always_comb begin
    active_nxt      = active_r;
    wait_nxt        = wait_r;
    acked_nxt       = acked_r;
    pending_nxt     = pending_r;
    tries_nxt       = tries_r;
    since_send_nxt  = since_send_r;
    since_start_nxt = since_start_r;
    arm_wait_nxt    = arm_wait_r;
    arm_pending_nxt = arm_pending_r;
    arm_since_nxt   = arm_since_r;
    area_nxt        = area_r;
    res_cnt         = 2'd0;
    res0            = '0;
    res1            = '0;
    unique case (item.mode)
      MODE_SPEAR_SEND: begin
        active_nxt      = 1'b1;
        wait_nxt        = 1'b1;
        acked_nxt       = 1'b0;
        pending_nxt     = item.cmd_code;
        tries_nxt       = 4'd1;
        since_send_nxt  = '0;
        since_start_nxt = '0;
        res_cnt         = 2'd1;
        res0            = mk_res(KIND_FRAME, 8'd0, item.cmd_code, area_r, 1'b0);
      end
      MODE_SPEAR_ACK: begin
        if (active_r && item.cmd_code == pending_r) begin
          wait_nxt        = 1'b0;
          acked_nxt       = 1'b1;
          since_start_nxt = '0;
        end
      end
      MODE_SPEAR_DONE: begin
        if (active_r && item.cmd_code == pending_r) begin
          active_nxt  = 1'b0;
          wait_nxt    = 1'b0;
          acked_nxt   = 1'b0;
          pending_nxt = '0;
          tries_nxt   = '0;
          res_cnt     = 2'd1;
          res0        = mk_res(KIND_EVENT, 8'd0, item.cmd_code, 8'd0, item.done_ok);
        end
      end
      MODE_TICK: begin
        area_nxt        = item.area_code;
        since_send_nxt  = ss_inc;
        since_start_nxt = st_inc;
        arm_since_nxt   = as_inc;
        if (active_r && pending_r != 8'd0) begin
          // A live spearhead command with a nonzero code blocks arm resends.
          if ((wait_r && ss_inc >= period_r) ||
              (!wait_r && acked_r && st_inc >= timeout_r)) begin
            res_cnt = 2'd1;
            if ((wait_r && tries_r >= max_retry_r) ||
                (!wait_r && tries_r >= max_retry_r)) begin
              // Attempts used up: give up with a failed event.
              active_nxt  = 1'b0;
              wait_nxt    = 1'b0;
              acked_nxt   = 1'b0;
              pending_nxt = '0;
              tries_nxt   = '0;
              res0        = mk_res(KIND_EVENT, 8'd0, pending_r, 8'd0, 1'b0);
            end else begin
              tries_nxt       = tries_r + 4'd1;
              since_send_nxt  = '0;
              since_start_nxt = '0;
              wait_nxt        = 1'b1;
              acked_nxt       = 1'b0;
              res0 = mk_res(KIND_FRAME, 8'd0, pending_r, item.area_code, 1'b0);
            end
          end
        end else if (arm_wait_r && as_inc >= period_r) begin
          arm_since_nxt = '0;
          res_cnt       = 2'd1;
          res0 = mk_res(KIND_FRAME, arm_pending_r, 8'd0, item.area_code, 1'b0);
        end
      end
      MODE_ARM_SEND: begin
        arm_pending_nxt = item.cmd_code;
        arm_wait_nxt    = 1'b1;
        arm_since_nxt   = '0;
        if (item.cmd_code != 8'd0) begin
          // Idle frame goes out ahead of the command.
          res_cnt   = 2'd2;
          res0      = mk_res(KIND_FRAME, 8'd0, 8'd0, area_r, 1'b0);
          res0.last = 1'b0;
          res1      = mk_res(KIND_FRAME, item.cmd_code, 8'd0, area_r, 1'b0);
        end else begin
          res_cnt = 2'd1;
          res0    = mk_res(KIND_FRAME, item.cmd_code, 8'd0, area_r, 1'b0);
        end
      end
      MODE_ARM_ACK: begin
        if (arm_wait_r && item.cmd_code == arm_pending_r) arm_wait_nxt = 1'b0;
      end
      MODE_ARM_DONE: begin
        arm_wait_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // State registers advance only on an item that is being processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      wait_r        <= 1'b0;
      acked_r       <= 1'b0;
      pending_r     <= '0;
      tries_r       <= '0;
      since_send_r  <= '0;
      since_start_r <= '0;
      arm_wait_r    <= 1'b0;
      arm_pending_r <= '0;
      arm_since_r   <= '0;
      area_r        <= '0;
    end else if (fire) begin
      active_r      <= active_nxt;
      wait_r        <= wait_nxt;
      acked_r       <= acked_nxt;
      pending_r     <= pending_nxt;
      tries_r       <= tries_nxt;
      since_send_r  <= since_send_nxt;
      since_start_r <= since_start_nxt;
      arm_wait_r    <= arm_wait_nxt;
      arm_pending_r <= arm_pending_nxt;
      arm_since_r   <= arm_since_nxt;
      area_r        <= area_nxt;
    end
  end

  // Waiting for ACK and waiting for DONE never overlap.
  `CADRE_ASSERT_IMPL(a_phase_excl, 1'b1, !(wait_r && acked_r))
  // An idle spearhead channel has no phase flags left over.
  `CADRE_ASSERT_IMPL(a_idle_clean, !active_r, !wait_r && !acked_r && tries_r == 4'd0)
  // A live spearhead command has used at least one attempt.
  `CADRE_ASSERT_IMPL(a_tries_live, active_r, tries_r != 4'd0)
  // Only an arm send of a nonzero command yields two results.
  `CADRE_ASSERT_IMPL(a_pair_src, fire && res_cnt == 2'd2,
                     item.mode == MODE_ARM_SEND && item.cmd_code != 8'd0)

endmodule

@@ src/cadre_obuf.sv @@
`include "command_ack_done_retry_engine_macros.svh"

// Result register: holds the results of one item and hands them out one beat at a time.
module cadre_obuf
  import cadre_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [1:0] res_cnt,
  input  res_t       res0,
  input  res_t       res1,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_data
);

  logic [1:0] cnt_r;
  logic       sel_r;
  res_t       res0_r, res1_r;

  // Room for a new item once the last held beat leaves.
  assign take      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = sel_r ? res1_r : res0_r;

  // Count of beats still to send, and which slot is shown.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      sel_r <= 1'b0;
    end else if (load) begin
      cnt_r <= res_cnt;
      sel_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      cnt_r <= cnt_r - 2'd1;
      sel_r <= 1'b1;
    end
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (load) begin
      res0_r <= res0;
      res1_r <= res1;
    end
  end

  `CADRE_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r != 2'd3)
  // The final beat of an item carries the last mark, the first of a pair does not.
  `CADRE_ASSERT_IMPL(a_last_final, cnt_r == 2'd1, out_data.last)
  `CADRE_ASSERT_IMPL(a_first_of_pair, cnt_r == 2'd2, !out_data.last && !sel_r)
  // A pair always shows its second slot after the first beat leaves.
  `CADRE_ASSERT_NEXT(a_pair_step, cnt_r == 2'd2 && out_ready && !load,
                     cnt_r == 2'd1 && sel_r)

endmodule

@@ sim/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cadre_pkg::*;

  // Mode 7 carries no operation; the block must ignore it.
  localparam logic [2:0]  MODE_UNUSED    = 3'd7;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          REPORT_LIMIT   = 10;
  localparam int          PHASE_ITEMS    = 80;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  res_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  // Register copies used by the predictor.
  logic [15:0] resend_period;
  logic [15:0] done_timeout;
  logic [3:0]  retry_limit;

  // Predicted channel state.
  logic        spear_active;
  logic        spear_wait_ack;
  logic        spear_acked;
  logic [7:0]  spear_pending;
  logic [3:0]  spear_tries;
  logic [15:0] spear_since_send;
  logic [15:0] spear_since_start;
  logic        arm_wait_ack;
  logic [7:0]  arm_pending;
  logic [15:0] arm_since_send;
  logic [7:0]  area_latch;

  // Frames and events produced by the item being predicted, then the ordered backlog.
  res_t        step_buf [2];
  int          step_n;
  res_t        expected_frames [$];

  int          error_count;
  int          quiet_cycles;
  int          stall_left;
  bit          allow_idle;

  command_ack_done_retry_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] count_up(input logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic void queue_result(input logic kind, input logic [7:0] st,
                                       input logic [7:0] sp, input logic [7:0] area,
                                       input logic ok);
    res_t r;
    r.kind        = kind;
    r.status_code = st;
    r.spear_code  = sp;
    r.area_out    = area;
    r.event_ok    = ok;
    r.last        = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endfunction

  function automatic void spear_drop();
    spear_active   = 1'b0;
    spear_wait_ack = 1'b0;
    spear_acked    = 1'b0;
    spear_pending  = 8'h00;
    spear_tries    = 4'd0;
  endfunction

  // Retry budget spent: post a failed done event for the abandoned command.
  function automatic void spear_abandon();
    logic [7:0] code;
    code = spear_pending;
    spear_drop();
    queue_result(KIND_EVENT, 8'h00, code, 8'h00, 1'b0);
  endfunction

  function automatic void spear_retransmit();
    spear_tries = spear_tries + 4'd1;
    queue_result(KIND_FRAME, 8'h00, spear_pending, area_latch, 1'b0);
    spear_since_send  = 16'd0;
    spear_since_start = 16'd0;
  endfunction

  function automatic void clear_prediction_state();
    resend_period     = RESEND_PERIOD_RST;
    done_timeout      = DONE_TIMEOUT_RST;
    retry_limit       = MAX_RETRY_RST;
    spear_drop();
    spear_since_send  = 16'd0;
    spear_since_start = 16'd0;
    arm_wait_ack      = 1'b0;
    arm_pending       = 8'h00;
    arm_since_send    = 16'd0;
    area_latch        = 8'h00;
  endfunction

  // Advances the predicted state by one item and queues the frames it should cause.
  function automatic void predict_frames(input in_t it);
    res_t r;
    step_n = 0;
    case (it.mode)
      MODE_SPEAR_SEND: begin
        spear_active      = 1'b1;
        spear_wait_ack    = 1'b1;
        spear_acked       = 1'b0;
        spear_pending     = it.cmd_code;
        spear_tries       = 4'd1;
        spear_since_send  = 16'd0;
        spear_since_start = 16'd0;
        queue_result(KIND_FRAME, 8'h00, it.cmd_code, area_latch, 1'b0);
      end
      MODE_SPEAR_ACK: begin
        if (spear_active && it.cmd_code == spear_pending) begin
          spear_wait_ack    = 1'b0;
          spear_acked       = 1'b1;
          spear_since_start = 16'd0;
        end
      end
      MODE_SPEAR_DONE: begin
        if (spear_active && it.cmd_code == spear_pending) begin
          spear_drop();
          queue_result(KIND_EVENT, 8'h00, it.cmd_code, 8'h00, it.done_ok);
        end
      end
      MODE_TICK: begin
        area_latch        = it.area_code;
        spear_since_send  = count_up(spear_since_send);
        spear_since_start = count_up(spear_since_start);
        arm_since_send    = count_up(arm_since_send);
        if (spear_active && spear_pending != 8'h00) begin
          // A live nonzero spearhead command owns the tick; arm resends wait.
          if (spear_wait_ack) begin
            if (spear_since_send >= resend_period) begin
              if (spear_tries >= retry_limit) spear_abandon();
              else spear_retransmit();
            end
          end else if (spear_acked && spear_since_start >= done_timeout) begin
            if (spear_tries < retry_limit) begin
              spear_retransmit();
              spear_wait_ack = 1'b1;
              spear_acked    = 1'b0;
            end else begin
              spear_abandon();
            end
          end
        end else if (arm_wait_ack && arm_since_send >= resend_period) begin
          queue_result(KIND_FRAME, arm_pending, 8'h00, area_latch, 1'b0);
          arm_since_send = 16'd0;
        end
      end
      MODE_ARM_SEND: begin
        if (it.cmd_code != 8'h00) queue_result(KIND_FRAME, 8'h00, 8'h00, area_latch, 1'b0);
        arm_pending    = it.cmd_code;
        arm_wait_ack   = 1'b1;
        arm_since_send = 16'd0;
        queue_result(KIND_FRAME, it.cmd_code, 8'h00, area_latch, 1'b0);
      end
      MODE_ARM_ACK: begin
        if (arm_wait_ack && it.cmd_code == arm_pending) arm_wait_ack = 1'b0;
      end
      MODE_ARM_DONE: begin
        arm_wait_ack = 1'b0;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < step_n; i++) begin
      r      = step_buf[i];
      r.last = (i == step_n - 1);
      expected_frames.push_back(r);
    end
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf("kind=%0d status=%02h spear=%02h area=%02h ok=%0d last=%0d",
                     r.kind, r.status_code, r.spear_code, r.area_out, r.event_ok, r.last);
  endfunction

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  function automatic logic [7:0] random_code();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if ($urandom_range(0, 9) == 0) c = 8'h00;
    return c;
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic random_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Presents one item, holds it until the block takes the beat, then predicts it.
  task automatic send_item(input mode_t mode, input logic [7:0] cmd, input logic ok,
                           input logic [7:0] area);
    in_t item;
    int  gap;
    item.mode      = mode;
    item.cmd_code  = cmd;
    item.done_ok   = ok;
    item.area_code = area;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frames(item);
  endtask

  task automatic send_tick(input logic [7:0] area);
    send_item(MODE_TICK, 8'h00, 1'b0, area);
  endtask

  // Stops the input side and lets the block drain before any register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] period, input logic [15:0] timeout,
                              input logic [3:0] retries);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_RESEND_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_idx   <= CFG_DONE_TIMEOUT;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_idx   <= CFG_MAX_RETRY;
    cfg_wdata <= {12'h000, retries};
    @(posedge clk);
    cfg_we        <= 1'b0;
    resend_period  = period;
    done_timeout   = timeout;
    retry_limit    = retries;
  endtask

  // Reset register values: first resend after five ticks, then ACK and DONE.
  task automatic test_reset_values();
    send_tick(8'h00);
    send_item(MODE_SPEAR_SEND, 8'hA5, 1'b0, 8'h00);
    repeat (4) send_tick(8'h00);
    send_tick(8'hFF);
    send_item(MODE_SPEAR_ACK, 8'hA5, 1'b0, 8'h00);
    send_item(MODE_SPEAR_DONE, 8'hA5, 1'b1, 8'h00);
    settle();
  endtask

  // Stale ACK and DONE, resend and give-up in both phases, and the zero command.
  task automatic test_spear_handshake();
    program_regs(16'd1, 16'd2, 4'd2);
    send_item(MODE_SPEAR_SEND, 8'hFF, 1'b0, 8'h00);
    send_item(MODE_SPEAR_ACK, 8'h00, 1'b0, 8'h00);
    send_item(MODE_SPEAR_DONE, 8'h00, 1'b1, 8'h00);
    send_tick(8'h3C);
    send_tick(8'hC3);
    send_item(MODE_SPEAR_SEND, 8'h5A, 1'b0, 8'h00);
    send_item(MODE_SPEAR_ACK, 8'h5A, 1'b0, 8'h00);
    send_tick(8'h01);
    send_tick(8'h02);
    send_item(MODE_SPEAR_ACK, 8'h5A, 1'b0, 8'h00);
    send_tick(8'h03);
    send_tick(8'h04);
    send_item(MODE_SPEAR_SEND, 8'h00, 1'b0, 8'h00);
    send_tick(8'h05);
    send_tick(8'h06);
    send_item(MODE_SPEAR_DONE, 8'h00, 1'b0, 8'h00);
    settle();
  endtask

  // Arm frames, mismatched ACK, hold-back under a live spearhead command, arm done.
  task automatic test_arm_handshake();
    send_item(MODE_ARM_SEND, 8'h00, 1'b0, 8'h00);
    send_item(MODE_ARM_ACK, 8'h01, 1'b0, 8'h00);
    send_tick(8'h10);
    send_item(MODE_ARM_SEND, 8'hFF, 1'b0, 8'h00);
    send_item(MODE_SPEAR_SEND, 8'h11, 1'b0, 8'h00);
    send_tick(8'h20);
    send_item(MODE_SPEAR_DONE, 8'h11, 1'b1, 8'h00);
    send_tick(8'h30);
    send_item(MODE_ARM_ACK, 8'hFF, 1'b0, 8'h00);
    send_tick(8'h40);
    send_item(MODE_ARM_SEND, 8'h3C, 1'b0, 8'h00);
    send_item(MODE_ARM_DONE, 8'h77, 1'b1, 8'hFF);
    send_tick(8'h50);
    send_item(mode_t'(MODE_UNUSED), 8'hFF, 1'b1, 8'hFF);
    settle();
  endtask

  // Zero period, timeout and budget: every tick expires and the first expiry gives up.
  task automatic test_zero_registers();
    program_regs(16'd0, 16'd0, 4'd0);
    send_item(MODE_SPEAR_SEND, 8'h42, 1'b0, 8'h00);
    send_tick(8'h81);
    send_item(MODE_SPEAR_SEND, 8'h43, 1'b0, 8'h00);
    send_item(MODE_SPEAR_ACK, 8'h43, 1'b0, 8'h00);
    send_tick(8'h82);
    send_item(MODE_ARM_SEND, 8'h00, 1'b0, 8'h00);
    send_tick(8'h83);
    send_tick(8'h84);
    send_item(MODE_ARM_DONE, 8'h00, 1'b0, 8'h00);
    settle();
  endtask

  // Mostly well-formed exchanges that echo the pending codes, plus stray traffic.
  task automatic random_traffic(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        send_tick(random_byte());
      end else if (pick < 45) begin
        send_item(MODE_SPEAR_SEND, random_code(), random_bit(), random_byte());
      end else if (pick < 58) begin
        send_item(MODE_SPEAR_ACK, ($urandom_range(0, 3) != 0) ? spear_pending : random_code(),
                  random_bit(), random_byte());
      end else if (pick < 68) begin
        send_item(MODE_SPEAR_DONE, ($urandom_range(0, 3) != 0) ? spear_pending : random_code(),
                  random_bit(), random_byte());
      end else if (pick < 80) begin
        send_item(MODE_ARM_SEND, random_code(), random_bit(), random_byte());
      end else if (pick < 89) begin
        send_item(MODE_ARM_ACK, ($urandom_range(0, 3) != 0) ? arm_pending : random_code(),
                  random_bit(), random_byte());
      end else if (pick < 93) begin
        send_item(MODE_ARM_DONE, random_code(), random_bit(), random_byte());
      end else begin
        send_item(mode_t'(3'($urandom_range(0, 7))), random_byte(), random_bit(),
                  random_byte());
      end
    end
  endtask

  // Random phases under different register settings, the extremes among them.
  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      allow_idle = (phase != 2) && (phase != 4);
      case (phase)
        0: program_regs(16'd1, 16'd1, 4'd1);
        1: program_regs(16'hFFFF, 16'hFFFF, 4'd15);
        2: program_regs(16'($urandom_range(1, 4)), 16'($urandom_range(2, 10)),
                        4'($urandom_range(1, 15)));
        3: program_regs(16'($urandom_range(1, 6)), 16'($urandom_range(1, 12)),
                        4'($urandom_range(2, 6)));
        default: program_regs(16'd2, 16'd3, 4'd15);
      endcase
      random_traffic(PHASE_ITEMS);
      settle();
    end
  endtask

  // Result side: random stall bursts while idling is allowed.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        note_failure($sformatf("unexpected result %s", describe(out_data)));
      end else begin
        want = expected_frames.pop_front();
        if (out_data.kind !== want.kind || out_data.status_code !== want.status_code ||
            out_data.spear_code !== want.spear_code || out_data.area_out !== want.area_out ||
            out_data.event_ok !== want.event_ok || out_data.last !== want.last)
          note_failure($sformatf("expected %s, got %s", describe(want), describe(out_data)));
      end
    end
  end

  // Ends a hung run: too many cycles without any beat or register write.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_RESEND_PERIOD;
    cfg_wdata   <= 16'd0;
    stall_left   = 0;
    quiet_cycles = 0;
    error_count  = 0;
    allow_idle   = 1'b1;
    clear_prediction_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_spear_handshake();
    test_arm_handshake();
    test_zero_registers();
    test_random_phases();

    if (expected_frames.size() != 0)
      note_failure($sformatf("%0d results never arrived, oldest %s",
                             expected_frames.size(), describe(expected_frames[0])));
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
